// ----- hdl/zgs_pkg.sv -----
// shared types, constants, float32 arithmetic and ziggurat table build for the gaussian sampler
package zgs_pkg;

  localparam int unsigned LAYER_COUNT = 128;
  localparam int unsigned LAYER_W     = $clog2(LAYER_COUNT);
  localparam logic [31:0] DEFAULT_SEED = 32'h1234_5678;
  localparam logic [31:0] LOG_BIAS     = 32'd1065353216;
  localparam logic [31:0] FP_ONE       = 32'h3F80_0000;

  typedef enum logic {
    OP_DRAW = 1'b0,
    OP_SEED = 1'b1
  } zgs_op_t;

  typedef struct packed {
    zgs_op_t     op;
    logic [31:0] seed;
  } zgs_cmd_t;

  typedef enum logic [2:0] {
    FOP_MUL    = 3'd0,
    FOP_ADD    = 3'd1,
    FOP_I2F_S  = 3'd2,
    FOP_I2F_U  = 3'd3,
    FOP_I2F_US = 3'd4,
    FOP_F2U    = 3'd5
  } zgs_fop_t;

  typedef logic [31:0] zgs_rom_t [LAYER_COUNT];

  // round to nearest even and pack
  function automatic logic [31:0] fp_pack(logic s, logic [9:0] e_in, logic [23:0] m,
                                          logic g, logic st);
    logic [24:0] mr;
    logic [9:0]  e;
    e  = e_in;
    mr = {1'b0, m} + 25'(g & (st | m[0]));
    if (mr[24]) begin
      mr = mr >> 1;
      e  = e + 10'd1;
    end
    if ($signed(e) <= 0) return {s, 31'b0};
    if ($signed(e) >= 255) return {s, 8'hFF, 23'b0};
    return {s, e[7:0], mr[22:0]};
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    logic        s;
    logic [9:0]  e;
    logic [47:0] p;
    logic [23:0] m;
    logic        g;
    logic        st;
    s = a[31] ^ b[31];
    if (a[30:23] == 8'd0 || b[30:23] == 8'd0) return {s, 31'b0};
    p = {1'b1, a[22:0]} * {1'b1, b[22:0]};
    e = {2'b0, a[30:23]} + {2'b0, b[30:23]} - 10'd127;
    if (p[47]) begin
      m  = p[47:24];
      g  = p[23];
      st = |p[22:0];
      e  = e + 10'd1;
    end else begin
      m  = p[46:23];
      g  = p[22];
      st = |p[21:0];
    end
    return fp_pack(s, e, m, g, st);
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] a_in, logic [31:0] b_in);
    logic [31:0]  a;
    logic [31:0]  b;
    logic [7:0]   d;
    logic [6:0]   dd;
    logic [49:0]  ma;
    logic [99:0]  ext;
    logic [49:0]  mbs;
    logic [50:0]  sum;
    logic [50:0]  n;
    logic [5:0]   pos;
    logic [9:0]   e;
    if (a_in[30:0] == 31'd0) begin
      if (b_in[30:0] == 31'd0) return {a_in[31] & b_in[31], 31'b0};
      return b_in;
    end
    if (b_in[30:0] == 31'd0) return a_in;
    if (b_in[30:0] > a_in[30:0]) begin
      a = b_in;
      b = a_in;
    end else begin
      a = a_in;
      b = b_in;
    end
    d   = a[30:23] - b[30:23];
    dd  = (d > 8'd99) ? 7'd99 : d[6:0];
    ma  = {1'b1, a[22:0], 26'b0};
    ext = {1'b1, b[22:0], 26'b0, 50'b0} >> dd;
    mbs = ext[99:50];
    mbs[0] = mbs[0] | (|ext[49:0]);
    if (a[31] == b[31]) sum = {1'b0, ma} + {1'b0, mbs};
    else sum = {1'b0, ma} - {1'b0, mbs};
    if (sum == 51'd0) return 32'd0;
    pos = 6'd0;
    for (int i = 0; i < 51; i++) begin
      if (sum[i]) pos = 6'(i);
    end
    n = sum << (6'd50 - pos);
    e = {2'b0, a[30:23]} + {4'b0, pos} - 10'd49;
    return fp_pack(a[31], e, n[50:27], n[26], |n[25:0]);
  endfunction

  // integer to float, optional exact scaling by 2^-32
  function automatic logic [31:0] fp_i2f(logic [31:0] v, logic sgn, logic scl);
    logic        neg;
    logic [31:0] mag;
    logic [31:0] n;
    logic [4:0]  pos;
    logic [9:0]  e;
    neg = sgn & v[31];
    mag = neg ? (32'd0 - v) : v;
    if (mag == 32'd0) return 32'd0;
    pos = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) pos = 5'(i);
    end
    n = mag << (5'd31 - pos);
    e = 10'd127 + {5'b0, pos} - (scl ? 10'd32 : 10'd0);
    return fp_pack(neg, e, n[31:8], n[7], |n[6:0]);
  endfunction

  // truncating float to unsigned, saturating
  function automatic logic [31:0] fp_f2u(logic [31:0] t);
    logic [63:0] w;
    logic [4:0]  sh;
    if (t[31] || t[30:23] == 8'd0) return 32'd0;
    if (t[30:23] >= 8'd159) return 32'hFFFF_FFFF;
    if (t[30:23] < 8'd127) return 32'd0;
    sh = 5'(t[30:23] - 8'd127);
    w  = (64'({1'b1, t[22:0]}) << sh) >> 23;
    return w[31:0];
  endfunction

  function automatic logic [31:0] fp_key(logic [31:0] x);
    if (x[30:0] == 31'd0) return 32'h8000_0000;
    return x[31] ? ~x : {1'b1, x[30:0]};
  endfunction

  function automatic logic fp_lt(logic [31:0] a, logic [31:0] b);
    return fp_key(a) < fp_key(b);
  endfunction

  function automatic logic fp_le(logic [31:0] a, logic [31:0] b);
    return fp_key(a) <= fp_key(b);
  endfunction

  // elaboration-time double helpers for the table build
  // correctly rounded double quotient by long division of the mantissas
  function automatic real r_div(real a, real b);
    logic [63:0] ba;
    logic [63:0] bb;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] rem;
    logic [63:0] q;
    logic [53:0] mr;
    logic        g;
    logic        st;
    int          e;
    if (a == 0.0) return 0.0;
    ba  = $realtobits(a);
    bb  = $realtobits(b);
    ma  = {11'b0, 1'b1, ba[51:0]};
    mb  = {11'b0, 1'b1, bb[51:0]};
    rem = ma;
    q   = 64'd0;
    for (int i = 0; i < 56; i++) begin
      q = q << 1;
      if (rem >= mb) begin
        q[0] = 1'b1;
        rem  = rem - mb;
      end
      rem = rem << 1;
    end
    e = int'(ba[62:52]) - int'(bb[62:52]) + 1023;
    if (q[55]) begin
      mr = {1'b0, q[55:3]};
      g  = q[2];
      st = (|q[1:0]) | (rem != 64'd0);
    end else begin
      mr = {1'b0, q[54:2]};
      g  = q[1];
      st = q[0] | (rem != 64'd0);
      e  = e - 1;
    end
    mr = mr + 54'(g & (st | mr[0]));
    if (mr[53]) begin
      mr = mr >> 1;
      e  = e + 1;
    end
    return $bitstoreal({ba[63] ^ bb[63], 11'(e), mr[51:0]});
  endfunction

  function automatic real r_pow2i(int k);
    logic [10:0] ex;
    ex = 11'(1023 + k);
    return $bitstoreal({1'b0, ex, 52'b0});
  endfunction

  function automatic real r_exp(real x_in);
    real x;
    real kf;
    real r;
    real p;
    int  k;
    x = x_in;
    if (!(x > -700.0)) return 0.0;
    if (x > 700.0) x = 700.0;
    kf = x * 1.4426950408889634;
    k  = $rtoi(kf < 0.0 ? kf - 0.5 : kf + 0.5);
    r  = (x - $itor(k) * 6.93147180369123816490e-01) - $itor(k) * 1.90821492927058770002e-10;
    p  = 1.0;
    for (int n = 22; n >= 1; n--) p = 1.0 + r_div(r * p, $itor(n));
    return p * r_pow2i(k);
  endfunction

  function automatic real r_log(real x);
    logic [63:0] b;
    real m;
    real s;
    real z;
    real p;
    int  e;
    if (!(x > 2.2250738585072014e-308)) return -745.0;
    b = $realtobits(x);
    e = int'(b[62:52]) - 1023;
    m = $bitstoreal({12'h3FF, b[51:0]});
    if (m > 1.4142135623730951) begin
      m = m * 0.5;
      e = e + 1;
    end
    s = r_div(m - 1.0, m + 1.0);
    z = s * s;
    p = r_div(1.0, 31.0);
    for (int j = 14; j >= 0; j--) p = r_div(1.0, $itor(2 * j + 1)) + z * p;
    return $itor(e) * 6.93147180369123816490e-01
           + (2.0 * s * p + $itor(e) * 1.90821492927058770002e-10);
  endfunction

  function automatic real r_sqrt(real x);
    logic [63:0] b;
    real r;
    if (!(x > 0.0)) return 0.0;
    b = $realtobits(x);
    b = (b >> 1) + 64'h1FF8_0000_0000_0000;
    r = $bitstoreal(b);
    for (int n = 0; n < 7; n++) r = 0.5 * (r + r_div(x, r));
    return r;
  endfunction

  function automatic logic [31:0] r_to_f(real v);
    logic [63:0] b;
    logic [9:0]  e;
    if (v == 0.0) return 32'd0;
    b = $realtobits(v);
    e = 10'(int'(b[62:52]) - 1023 + 127);
    return fp_pack(b[63], e, {1'b1, b[51:29]}, b[28], |b[27:0]);
  endfunction

  function automatic logic [31:0] r_to_thr(real v);
    if (!(v > 0.0)) return 32'd0;
    if (v >= 2147483647.0) return 32'h7FFF_FFFF;
    return 32'($rtoi(v));
  endfunction

  // sel: 0 threshold, 1 density, 2 width
  function automatic zgs_rom_t build_rom(int sel);
    zgs_rom_t thr;
    zgs_rom_t den;
    zgs_rom_t wid;
    real m1;
    real vn;
    real dn;
    real prev;
    real q;
    m1 = 2147483648.0;
    vn = 9.91256303526217E-03;
    dn = 3.442619855899;
    for (int i = 0; i < LAYER_COUNT; i++) begin
      thr[i] = 32'd0;
      den[i] = 32'd0;
      wid[i] = 32'd0;
    end
    q = r_div(vn, r_exp(-0.5 * dn * dn));
    thr[0] = r_to_thr(r_div(dn, q) * m1);
    thr[1] = 32'd0;
    wid[0] = r_to_f(r_div(q, m1));
    wid[LAYER_COUNT-1] = r_to_f(r_div(dn, m1));
    den[0] = FP_ONE;
    den[LAYER_COUNT-1] = r_to_f(r_exp(-0.5 * dn * dn));
    for (int i = LAYER_COUNT - 2; i >= 1; i--) begin
      prev = dn;
      dn = r_sqrt(-2.0 * r_log(r_div(vn, dn) + r_exp(-0.5 * dn * dn)));
      thr[i+1] = r_to_thr(r_div(dn, prev) * m1);
      den[i]   = r_to_f(r_exp(-0.5 * dn * dn));
      wid[i]   = r_to_f(r_div(dn, m1));
    end
    if (sel == 0) return thr;
    if (sel == 1) return den;
    return wid;
  endfunction

  localparam zgs_rom_t THR_ROM = build_rom(0);
  localparam zgs_rom_t DEN_ROM = build_rom(1);
  localparam zgs_rom_t WID_ROM = build_rom(2);

  localparam logic [31:0] C_WEDGE_A = r_to_f(-6169045.423972);
  localparam logic [31:0] C_WEDGE_B = r_to_f(1065101626.864132);
  localparam logic [31:0] C_TAIL_SX = r_to_f(2.30830217163e-08);
  localparam logic [31:0] C_TAIL_SY = r_to_f(7.94660834913e-08);
  localparam logic [31:0] C_TAIL_R  = r_to_f(3.442620);

endpackage

// ----- hdl/ziggurat_gaussian_sampler.sv -----
// top level of the 128-layer ziggurat gaussian sampler
// A draw transaction (operation 0) returns one IEEE single-precision normal
// sample; a seed transaction (operation 1) replaces the 32-bit xorshift-add
// generator word and returns nothing. Reset seeds the generator with
// 0x12345678. Intake is a two-entry queue, so up to two transactions are
// taken while the engine works, and a finished sample sits in the output
// register without holding up the engine. The sequencer drives a single
// shared float32 unit: a draw passing the fast layer test goes from the
// queue through GEN, CVT, MULW and DEC to OUT, which loads the output
// register, and the engine is then idle for the next transaction; a wedge
// try runs WG, WY and W1 to W8, and a failed one goes back to GEN to draw
// and test a new layer; a tail try runs TG to TM for each of two uniform
// draws, then TP, TQ and TCMP to test, and TS to apply the sign once
// accepted. A full output register holds the engine until the sample is
// taken. A seed is taken in the idle state. The layer tables are constant
// logic built during elaboration, so there is no start-up pass.
module ziggurat_gaussian_sampler (
  input  logic        clk,
  input  logic        rst_n,
  // request transactions
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [31:0] in_seed_value,
  // sample transactions
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sample_bits
);
  import zgs_pkg::*;

  // queue to engine
  logic      cmd_valid;
  logic      cmd_ready;
  zgs_cmd_t  cmd;

  zgs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_seed_value (in_seed_value),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_ready     (cmd_ready)
  );

  // rejection loop runs here until a sample is accepted
  zgs_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_ready       (cmd_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample_bits (out_sample_bits)
  );

endmodule

// ----- hdl/zgs_front.sv -----
// request intake: accepts transactions and queues them for the sampling engine
module zgs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [31:0]        in_seed_value,
  output logic               cmd_valid,
  output zgs_pkg::zgs_cmd_t  cmd,
  input  logic               cmd_ready
);
  import zgs_pkg::*;

  zgs_cmd_t    q_r [2];
  logic        wp_r;
  logic        rp_r;
  logic [1:0]  cnt_r;
  logic        push;
  logic        pop;
  zgs_cmd_t    item;

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push      = in_valid & in_ready;
  assign pop       = cmd_valid & cmd_ready;

  // classify the request at intake
  always_comb begin
    item.op   = in_operation ? OP_SEED : OP_DRAW;
    item.seed = in_seed_value;
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- hdl/zgs_fpu.sv -----
// shared float32 unit: multiply, add, integer conversions
module zgs_fpu (
  input  zgs_pkg::zgs_fop_t  op,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  output logic [31:0]        res
);
  import zgs_pkg::*;

  always_comb begin
    case (op)
      FOP_MUL:    res = fp_mul(a, b);
      FOP_ADD:    res = fp_add(a, b);
      FOP_I2F_S:  res = fp_i2f(a, 1'b1, 1'b0);
      FOP_I2F_U:  res = fp_i2f(a, 1'b0, 1'b0);
      FOP_I2F_US: res = fp_i2f(a, 1'b0, 1'b1);
      FOP_F2U:    res = fp_f2u(a);
      default:    res = 32'd0;
    endcase
  end

endmodule

// ----- hdl/zgs_engine.sv -----
// sampling engine: generator, ziggurat rejection sequencer and result register
module zgs_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  zgs_pkg::zgs_cmd_t  cmd,
  output logic               cmd_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_sample_bits
);
  import zgs_pkg::*;

  typedef enum logic [24:0] {
    ST_IDLE = 25'h0000001,
    ST_GEN  = 25'h0000002,
    ST_CVT  = 25'h0000004,
    ST_MULW = 25'h0000008,
    ST_DEC  = 25'h0000010,
    ST_WG   = 25'h0000020,
    ST_WY   = 25'h0000040,
    ST_W1   = 25'h0000080,
    ST_W2   = 25'h0000100,
    ST_W3   = 25'h0000200,
    ST_W4   = 25'h0000400,
    ST_W5   = 25'h0000800,
    ST_W6   = 25'h0001000,
    ST_W7   = 25'h0002000,
    ST_W8   = 25'h0004000,
    ST_TG   = 25'h0008000,
    ST_TC   = 25'h0010000,
    ST_TK   = 25'h0020000,
    ST_TI   = 25'h0040000,
    ST_TM   = 25'h0080000,
    ST_TP   = 25'h0100000,
    ST_TQ   = 25'h0200000,
    ST_TCMP = 25'h0400000,
    ST_TS   = 25'h0800000,
    ST_OUT  = 25'h1000000
  } zgs_state_t;

  zgs_state_t          state_r;
  zgs_state_t          state_nxt;
  logic [31:0]         gw_r;
  logic [31:0]         hz_r;
  logic [31:0]         u_r;
  logic [31:0]         x_r;
  logic [31:0]         y_r;
  logic [31:0]         t_r;
  logic [31:0]         d_r;
  logic                fast_r;
  logic                tail_y_r;
  logic                out_valid_r;
  logic [31:0]         out_bits_r;

  logic [31:0]         w1;
  logic [31:0]         w2;
  logic [31:0]         w3;
  logic [31:0]         gen_val;
  logic [LAYER_W-1:0]  iz;
  logic [LAYER_W-1:0]  iz_m1;
  logic [31:0]         mag;
  logic                fast;
  logic                slot_free;
  logic [31:0]         den_cur;
  zgs_fop_t            fop;
  logic [31:0]         fa;
  logic [31:0]         fb;
  logic [31:0]         fres;

  // xorshift step, output is old word plus new word
  assign w1      = gw_r ^ (gw_r << 13);
  assign w2      = w1 ^ (w1 >> 17);
  assign w3      = w2 ^ (w2 << 5);
  assign gen_val = gw_r + w3;

  assign iz      = hz_r[LAYER_W-1:0];
  assign iz_m1   = iz - LAYER_W'(1);
  assign den_cur = DEN_ROM[iz];
  // magnitude wraps for the most negative word
  assign mag     = hz_r[31] ? (32'd0 - hz_r) : hz_r;
  assign fast    = $signed(mag) < $signed(THR_ROM[iz]);

  assign slot_free       = !out_valid_r || out_ready;
  assign cmd_ready       = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_sample_bits = out_bits_r;

  zgs_fpu u_fpu (
    .op  (fop),
    .a   (fa),
    .b   (fb),
    .res (fres)
  );

  always_comb begin
    fop = FOP_MUL;
    fa  = x_r;
    fb  = x_r;
    case (state_r)
      ST_CVT:  begin fop = FOP_I2F_S;  fa = hz_r; end
      ST_MULW: begin fop = FOP_MUL;    fa = WID_ROM[iz]; fb = x_r; end
      ST_WY:   begin fop = FOP_I2F_US; fa = u_r; end
      ST_W1:   begin fop = FOP_MUL;    fa = C_WEDGE_A; fb = x_r; end
      ST_W2:   begin fop = FOP_MUL;    fa = t_r; fb = x_r; end
      ST_W3:   begin fop = FOP_ADD;    fa = t_r; fb = C_WEDGE_B; end
      ST_W4:   begin fop = FOP_F2U;    fa = t_r; end
      ST_W5:   begin
        fop = FOP_ADD;
        fa  = DEN_ROM[iz_m1];
        fb  = {~den_cur[31], den_cur[30:0]};
      end
      ST_W6:   begin fop = FOP_MUL;    fa = y_r; fb = d_r; end
      ST_W7:   begin fop = FOP_ADD;    fa = y_r; fb = den_cur; end
      ST_TC:   begin fop = FOP_I2F_US; fa = u_r; end
      ST_TI:   begin fop = FOP_I2F_U;  fa = u_r; end
      ST_TM:   begin fop = FOP_MUL;    fa = d_r; fb = tail_y_r ? C_TAIL_SY : C_TAIL_SX; end
      ST_TP:   begin fop = FOP_MUL;    fa = x_r; fb = x_r; end
      ST_TQ:   begin fop = FOP_ADD;    fa = y_r; fb = y_r; end
      ST_TCMP: begin fop = FOP_ADD;    fa = x_r; fb = C_TAIL_R; end
      default: begin fop = FOP_MUL;    fa = x_r; fb = x_r; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (cmd_valid && cmd.op == OP_DRAW) state_nxt = ST_GEN;
      ST_GEN:  state_nxt = ST_CVT;
      ST_CVT:  state_nxt = ST_MULW;
      ST_MULW: state_nxt = ST_DEC;
      ST_DEC: begin
        if (fast_r) state_nxt = ST_OUT;
        else if (iz == LAYER_W'(0)) state_nxt = ST_TG;
        else state_nxt = ST_WG;
      end
      ST_WG:   state_nxt = ST_WY;
      ST_WY:   state_nxt = ST_W1;
      ST_W1:   state_nxt = ST_W2;
      ST_W2:   state_nxt = ST_W3;
      ST_W3:   state_nxt = ST_W4;
      ST_W4:   state_nxt = ST_W5;
      ST_W5:   state_nxt = ST_W6;
      ST_W6:   state_nxt = ST_W7;
      ST_W7:   state_nxt = ST_W8;
      ST_W8:   state_nxt = fp_lt(y_r, t_r) ? ST_OUT : ST_GEN;
      ST_TG:   state_nxt = ST_TC;
      ST_TC:   state_nxt = ST_TK;
      ST_TK:   state_nxt = ST_TI;
      ST_TI:   state_nxt = ST_TM;
      ST_TM:   state_nxt = tail_y_r ? ST_TP : ST_TG;
      ST_TP:   state_nxt = ST_TQ;
      ST_TQ:   state_nxt = ST_TCMP;
      ST_TCMP: state_nxt = fp_le(t_r, d_r) ? ST_TS : ST_TG;
      ST_TS:   state_nxt = ST_OUT;
      ST_OUT:  if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_GEN:  hz_r <= gen_val;
      ST_CVT:  begin x_r <= fres; fast_r <= fast; end
      ST_MULW: x_r <= fres;
      ST_WG:   u_r <= gen_val;
      ST_WY:   y_r <= fres;
      ST_W1:   t_r <= fres;
      ST_W2:   t_r <= fres;
      ST_W3:   t_r <= fres;
      ST_W4:   t_r <= fres;
      ST_W5:   d_r <= fres;
      ST_W6:   y_r <= fres;
      ST_W7:   y_r <= fres;
      ST_TG:   u_r <= gen_val;
      ST_TC:   t_r <= fres;
      ST_TK:   u_r <= LOG_BIAS - t_r;
      ST_TI:   d_r <= fres;
      ST_TM:   if (tail_y_r) y_r <= fres; else x_r <= fres;
      ST_TP:   t_r <= fres;
      ST_TQ:   d_r <= fres;
      ST_TCMP: if (fp_le(t_r, d_r)) x_r <= fres;
      ST_TS:   x_r <= x_r ^ {hz_r[31], 31'b0};
      ST_OUT:  if (slot_free) out_bits_r <= x_r;
      default: ;
    endcase
  end

  // control registers and generator word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gw_r        <= DEFAULT_SEED;
      tail_y_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && slot_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (cmd_valid && cmd.op == OP_SEED) gw_r <= cmd.seed;
        ST_GEN:  gw_r <= w3;
        ST_WG:   gw_r <= w3;
        ST_TG:   gw_r <= w3;
        ST_DEC:  tail_y_r <= 1'b0;
        ST_TM:   tail_y_r <= ~tail_y_r;
        ST_TCMP: tail_y_r <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/zgs_checker.sv -----
// port-level checks for the gaussian sampler, bound to the top level
module zgs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_operation,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_sample_bits
);

  logic [3:0] pend_r;
  logic       draw_in;
  logic       take_out;

  assign draw_in  = in_valid && in_ready && !in_operation;
  assign take_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= 4'd0;
    else pend_r <= pend_r + 4'(draw_in) - 4'(take_out);
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("sample shown straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_bits))
    else $error("stalled sample changed or dropped");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("sample without a pending draw");

  a_finite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample_bits[30:23] != 8'hFF)
    else $error("sample is not finite");

endmodule

bind ziggurat_gaussian_sampler zgs_checker u_zgs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_operation    (in_operation),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_sample_bits (out_sample_bits)
);

// ----- verif/tb_top.sv -----
// self-checking testbench for the ziggurat gaussian sampler
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import zgs_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_operation;
  logic [31:0] in_seed_value;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_sample_bits;

  ziggurat_gaussian_sampler i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_seed_value   (in_seed_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample_bits (out_sample_bits)
  );

  // ---------------------------------------------------------------------
  // predictor state: generator word and our own copy of the layer tables
  // ---------------------------------------------------------------------
  logic [31:0] gen_word;
  logic [31:0] thr_tab [LAYER_COUNT];
  logic [31:0] den_tab [LAYER_COUNT];
  logic [31:0] wid_tab [LAYER_COUNT];
  logic [31:0] k_wedge_a;
  logic [31:0] k_wedge_b;
  logic [31:0] k_tail_sx;
  logic [31:0] k_tail_sy;
  logic [31:0] k_tail_r;

  logic [31:0] sample_q [$];   // samples still owed by the block

  int unsigned n_fail;
  int unsigned n_draws;
  int unsigned n_seeds;
  int unsigned n_checked;
  int unsigned n_tail;

  // sender and receiver control
  bit          send_steady;    // no idle gaps on the request side
  bit          recv_steady;    // no stalls on the sample side
  bit          hold_req;
  int unsigned hold_left;

  // ---------------------------------------------------------------------
  // float32 helpers, round to nearest even, denormals flushed to zero
  // ---------------------------------------------------------------------
  // value = mag * 2^pow2, rounded into a single
  function automatic logic [31:0] f32_round(logic s, int pow2, logic [63:0] mag);
    int          msb;
    int          sh;
    int          be;
    logic [63:0] m;
    logic        g;
    logic        st;
    if (mag == 64'd0) return {s, 31'b0};
    msb = 0;
    for (int i = 0; i < 64; i++) if (mag[i]) msb = i;
    g  = 1'b0;
    st = 1'b0;
    if (msb <= 23) begin
      m = mag << (23 - msb);
    end else begin
      sh = msb - 23;
      m  = mag >> sh;
      g  = mag[sh-1];
      st = |(mag & ((64'd1 << (sh - 1)) - 64'd1));
    end
    be = pow2 + msb + 127;
    if (g && (st || m[0])) m = m + 64'd1;
    if (m[24]) begin
      m  = m >> 1;
      be = be + 1;
    end
    if (be >= 255) return {s, 8'hFF, 23'b0};
    if (be <= 0) return {s, 31'b0};
    return {s, 8'(be), m[22:0]};
  endfunction

  function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
    logic s;
    s = a[31] ^ b[31];
    if (a[30:23] == 8'd0 || b[30:23] == 8'd0) return {s, 31'b0};
    return f32_round(s, int'(a[30:23]) + int'(b[30:23]) - 254 - 46,
                     64'({1'b1, a[22:0]}) * 64'({1'b1, b[22:0]}));
  endfunction

  function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
    logic [31:0] hi;
    logic [31:0] lo;
    logic [63:0] mh;
    logic [63:0] ml;
    logic [63:0] sum;
    int          dd;
    if (a[30:23] == 8'd0) begin
      if (b[30:23] == 8'd0) return {a[31] & b[31], 31'b0};
      return b;
    end
    if (b[30:23] == 8'd0) return a;
    if (b[30:0] > a[30:0]) begin
      hi = b;
      lo = a;
    end else begin
      hi = a;
      lo = b;
    end
    dd = int'(hi[30:23]) - int'(lo[30:23]);
    mh = 64'({1'b1, hi[22:0]}) << 38;
    ml = 64'({1'b1, lo[22:0]}) << 38;
    if (dd >= 62) ml = 64'd1;
    else if (dd > 0) ml = (ml >> dd) | 64'(|(ml & ((64'd1 << dd) - 64'd1)));
    sum = (hi[31] == lo[31]) ? mh + ml : mh - ml;
    if (sum == 64'd0) return 32'd0;
    return f32_round(hi[31], int'(hi[30:23]) - 127 - 23 - 38, sum);
  endfunction

  // signed or unsigned word to float, optionally times 2^-32
  function automatic logic [31:0] f32_from_int(logic [31:0] v, bit is_signed, bit by_2m32);
    logic        neg;
    logic [31:0] mag;
    neg = is_signed && v[31];
    mag = neg ? -v : v;
    if (mag == 32'd0) return 32'd0;
    return f32_round(neg, by_2m32 ? -32 : 0, 64'(mag));
  endfunction

  // truncating, saturating float to unsigned word
  function automatic logic [31:0] f32_to_uint(logic [31:0] t);
    int          ex;
    logic [63:0] m;
    if (t[31] || t[30:23] == 8'd0) return 32'd0;
    ex = int'(t[30:23]);
    if (ex >= 159) return 32'hFFFF_FFFF;
    if (ex < 127) return 32'd0;
    m = 64'({1'b1, t[22:0]});
    if (ex >= 150) m = m << (ex - 150);
    else m = m >> (150 - ex);
    return m[31:0];
  endfunction

  // monotonic ordering key, both zeros equal
  function automatic logic [31:0] f32_order(logic [31:0] x);
    if (x[30:0] == 31'd0) return 32'h8000_0000;
    return x[31] ? ~x : {1'b1, x[30:0]};
  endfunction

  function automatic logic [31:0] dbl_to_f32(real v);
    logic [63:0] b;
    if (v == 0.0) return 32'd0;
    b = $realtobits(v);
    return f32_round(b[63], int'(b[62:52]) - 1023 - 52, 64'({1'b1, b[51:0]}));
  endfunction

  // ---------------------------------------------------------------------
  // double precision table build, same recurrence as the block's setup
  // ---------------------------------------------------------------------
  function automatic real d_exp(real x_in);
    real x;
    real kf;
    real r;
    real p;
    int  k;
    x = x_in;
    if (!(x > -700.0)) return 0.0;
    if (x > 700.0) x = 700.0;
    kf = x * 1.4426950408889634;
    k  = $rtoi(kf < 0.0 ? kf - 0.5 : kf + 0.5);
    r  = (x - $itor(k) * 6.93147180369123816490e-01) - $itor(k) * 1.90821492927058770002e-10;
    p  = 1.0;
    for (int n = 22; n >= 1; n--) p = 1.0 + r * p / $itor(n);
    return p * $bitstoreal({1'b0, 11'(1023 + k), 52'b0});
  endfunction

  function automatic real d_log(real x);
    logic [63:0] b;
    real         m;
    real         s;
    real         z;
    real         p;
    int          ex;
    if (!(x > 2.2250738585072014e-308)) return -745.0;
    b  = $realtobits(x);
    ex = int'(b[62:52]) - 1023;
    m  = $bitstoreal({12'h3FF, b[51:0]});
    if (m > 1.4142135623730951) begin
      m  = m * 0.5;
      ex = ex + 1;
    end
    s = (m - 1.0) / (m + 1.0);
    z = s * s;
    p = 1.0 / 31.0;
    for (int j = 14; j >= 0; j--) p = 1.0 / $itor(2 * j + 1) + z * p;
    return $itor(ex) * 6.93147180369123816490e-01
           + (2.0 * s * p + $itor(ex) * 1.90821492927058770002e-10);
  endfunction

  function automatic real d_sqrt(real x);
    logic [63:0] b;
    real         r;
    if (!(x > 0.0)) return 0.0;
    b = $realtobits(x);
    b = (b >> 1) + 64'h1FF8_0000_0000_0000;
    r = $bitstoreal(b);
    for (int n = 0; n < 7; n++) r = 0.5 * (r + x / r);
    return r;
  endfunction

  function automatic logic [31:0] dbl_to_thr(real v);
    if (!(v > 0.0)) return 32'd0;
    if (v >= 2147483647.0) return 32'h7FFF_FFFF;
    return 32'($rtoi(v));
  endfunction

  task automatic build_layer_tables();
    real m1;
    real vn;
    real dn;
    real prev;
    real q;
    m1 = 2147483648.0;
    vn = 9.91256303526217E-03;
    dn = 3.442619855899;
    q  = vn / d_exp(-0.5 * dn * dn);
    thr_tab[0] = dbl_to_thr(dn / q * m1);
    thr_tab[1] = 32'd0;
    wid_tab[0] = dbl_to_f32(q / m1);
    wid_tab[LAYER_COUNT-1] = dbl_to_f32(dn / m1);
    den_tab[0] = 32'h3F80_0000;
    den_tab[LAYER_COUNT-1] = dbl_to_f32(d_exp(-0.5 * dn * dn));
    for (int i = LAYER_COUNT - 2; i >= 1; i--) begin
      prev = dn;
      dn   = d_sqrt(-2.0 * d_log(vn / dn + d_exp(-0.5 * dn * dn)));
      thr_tab[i+1] = dbl_to_thr(dn / prev * m1);
      den_tab[i]   = dbl_to_f32(d_exp(-0.5 * dn * dn));
      wid_tab[i]   = dbl_to_f32(dn / m1);
    end
    k_wedge_a = dbl_to_f32(-6169045.423972);
    k_wedge_b = dbl_to_f32(1065101626.864132);
    k_tail_sx = dbl_to_f32(2.30830217163e-08);
    k_tail_sy = dbl_to_f32(7.94660834913e-08);
    k_tail_r  = dbl_to_f32(3.442620);
  endtask

  // ---------------------------------------------------------------------
  // sampler model
  // ---------------------------------------------------------------------
  // xorshift step, returns old word plus new word
  function automatic logic [31:0] rng_step();
    logic [31:0] old_w;
    logic [31:0] w;
    old_w = gen_word;
    w = gen_word;
    w = w ^ (w << 13);
    w = w ^ (w >> 17);
    w = w ^ (w << 5);
    gen_word = w;
    return old_w + w;
  endfunction

  // fast layer test; the most negative word wraps to itself
  function automatic bit layer_accepts(logic [31:0] hz);
    longint sv;
    longint mag;
    sv  = longint'($signed(hz));
    mag = (sv < 0) ? -sv : sv;
    if (mag > 64'sd2147483647) mag = mag - 64'sd4294967296;
    return mag < longint'($signed(thr_tab[hz[6:0]]));
  endfunction

  // bit-trick log of a uniform variate, then scaled
  function automatic logic [31:0] log_trick(logic [31:0] u, logic [31:0] scale);
    logic [31:0] t;
    t = f32_from_int(u, 1'b0, 1'b1);
    return f32_mul(f32_from_int(32'd1065353216 - t, 1'b1, 1'b0), scale);
  endfunction

  function automatic logic [31:0] gaussian_sample();
    logic [31:0] hz;
    logic [6:0]  iz;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] e;
    logic [31:0] d;
    logic [31:0] lhs;
    hz = rng_step();
    iz = hz[6:0];
    if (layer_accepts(hz)) return f32_mul(wid_tab[iz], f32_from_int(hz, 1'b1, 1'b0));
    while (1) begin
      if (iz == 7'd0) begin
        // tail beyond the base strip
        n_tail++;
        while (1) begin
          x = log_trick(rng_step(), k_tail_sx);
          y = log_trick(rng_step(), k_tail_sy);
          if (f32_order(f32_mul(x, x)) <= f32_order(f32_add(y, y))) begin
            x = f32_add(x, k_tail_r);
            return {hz[31] ^ x[31], x[30:0]};
          end
        end
      end
      // wedge test against the exp bit trick
      y   = f32_from_int(rng_step(), 1'b0, 1'b1);
      x   = f32_mul(wid_tab[iz], f32_from_int(hz, 1'b1, 1'b0));
      e   = f32_to_uint(f32_add(f32_mul(f32_mul(k_wedge_a, x), x), k_wedge_b));
      d   = f32_add(den_tab[iz-1], {~den_tab[iz][31], den_tab[iz][30:0]});
      lhs = f32_add(f32_mul(y, d), den_tab[iz]);
      if (f32_order(lhs) < f32_order(e)) return x;
      hz = rng_step();
      iz = hz[6:0];
      if (layer_accepts(hz)) return f32_mul(wid_tab[iz], f32_from_int(hz, 1'b1, 1'b0));
    end
    return 32'd0;
  endfunction

  // ---------------------------------------------------------------------
  // clock, limit
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("timeout at %0t, %0d samples still owed", $time, sample_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------
  // request monitor: each accepted transaction updates the model
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (zgs_op_t'(in_operation) == OP_SEED) begin
        gen_word = in_seed_value;
        n_seeds++;
      end else begin
        sample_q.push_back(gaussian_sample());
        n_draws++;
      end
    end
  end

  // sample checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (sample_q.size() == 0) begin
        $display("%0t: unexpected sample, expected none, actual %h", $time, out_sample_bits);
        n_fail++;
      end else begin
        if (out_sample_bits !== sample_q[0]) begin
          $display("%0t: sample_bits mismatch, expected %h, actual %h",
                   $time, sample_q[0], out_sample_bits);
          n_fail++;
        end
        void'(sample_q.pop_front());
        n_checked++;
      end
    end
  end

  // receiver: random stalls, or a long counted hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 80;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= recv_steady || ($urandom_range(99) >= 28);
    end
  end

  // ---------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------
  task automatic send_request(zgs_op_t op, logic [31:0] seed);
    if (!send_steady && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_seed_value <= seed;
    do @(posedge clk); while (!in_ready);
  endtask

  // let the monitor see the last handshake first so the last accepted draw is already owed
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sample_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  // draws after reset, then the seed corner cases including the zero word
  task automatic test_seed_corners();
    logic [31:0] seeds [6];
    seeds = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
              32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001};
    repeat (3) send_request(OP_DRAW, $urandom);
    foreach (seeds[i]) begin
      send_request(OP_SEED, seeds[i]);
      repeat (2) send_request(OP_DRAW, $urandom);
    end
    wait_drained();
  endtask

  // well-formed traffic: mostly draws, the odd reseed, one burst with no gaps
  task automatic test_random_traffic();
    for (int i = 0; i < 400; i++) begin
      send_steady = (i >= 150 && i < 250);
      recv_steady = send_steady;
      if ($urandom_range(99) < 8) begin
        // keep the all-zero word rare, it pins the generator
        send_request(OP_SEED, ($urandom_range(49) == 0) ? 32'd0 : $urandom);
      end else begin
        send_request(OP_DRAW, $urandom);
      end
      // leave a stuck zero generator behind quickly
      if (gen_word == 32'd0 && $urandom_range(3) == 0) send_request(OP_SEED, $urandom);
    end
    send_steady = 1'b0;
    recv_steady = 1'b0;
  endtask

  // receiver holds off while draws keep coming, so the intake fills up
  task automatic test_output_stall();
    hold_req    = 1'b1;
    send_steady = 1'b1;
    repeat (12) send_request(OP_DRAW, $urandom);
    send_steady = 1'b0;
    wait_drained();
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_operation  <= OP_DRAW;
    in_seed_value <= 32'd0;
    gen_word    = DEFAULT_SEED;
    send_steady = 1'b0;
    recv_steady = 1'b0;
    hold_req    = 1'b0;
    hold_left   = 0;
    n_fail      = 0;
    n_draws     = 0;
    n_seeds     = 0;
    n_checked   = 0;
    n_tail      = 0;
    build_layer_tables();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_seed_corners();
    test_output_stall();
    test_random_traffic();
    test_output_stall();
    wait_drained();
    repeat (60) @(posedge clk);

    $display("covered %0d draw and %0d seed transactions, %0d samples checked",
             n_draws, n_seeds, n_checked);
    $display("tail strip entered %0d times, zero and extreme seeds included", n_tail);
    if (n_fail == 0 && sample_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d samples never arrived", n_fail, sample_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
